### hw/rtl/pgs_pkg.sv
package pgs_pkg;

   localparam int COORD_W       = 32;
   localparam int ANGLE_W       = 16;
   localparam int CORDIC_STAGES = 20;
   localparam int GUARD_W       = 27;
   localparam int DATA_W        = 64;
   localparam int PHASE_W       = 32;
   localparam int STAGE_IDX_W   = 5;
   localparam int STEP_W        = 31;
   localparam int NDIV_W        = 13;
   localparam int DEN_W         = 32;
   localparam int REM_W         = 33;
   localparam int DIV_W         = 48;
   localparam int KINV_W        = 24;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 32;

   // Inverse CORDIC gain, Q0.24.
   localparam logic [KINV_W-1:0] KINV = 24'd10188014;

   localparam logic [PHASE_W-1:0] HALF_TURN = 32'h8000_0000;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_STEP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVISION_COUNT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION_ANGLE = 3'd4;

   localparam logic MODE_VECTOR = 1'b0;
   localparam logic MODE_ROTATE = 1'b1;

   typedef struct packed {
      logic              valid;
      logic              on_origin;
      logic              neg;
      logic              axis;
      logic [1:0]        quad;
      logic [DATA_W-1:0] side;
   } ctx_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic [PHASE_W-1:0]       ang;
   } vec_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [DIV_W-1:0] nq;
   } div_lane_type;

   // atan(2^-i) in phase units of 2^-32 turn, truncated.
   function automatic logic [PHASE_W-1:0] atan_phase(input logic [STAGE_IDX_W-1:0] idx);
      logic [PHASE_W-1:0] a;
      case (idx)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051D;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2E;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2F9;
         5'd15: a = 32'h0000517C;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A2F;
         5'd19: a = 32'h00000517;
         5'd20: a = 32'h0000028B;
         5'd21: a = 32'h00000145;
         5'd22: a = 32'h000000A2;
         5'd23: a = 32'h00000051;
         5'd24: a = 32'h00000028;
         5'd25: a = 32'h00000014;
         5'd26: a = 32'h0000000A;
         5'd27: a = 32'h00000005;
         5'd28: a = 32'h00000002;
         5'd29: a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

### hw/rtl/pgs_if.sv
interface pgs_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [pgs_pkg::COORD_W-1:0]  point_x;
   logic signed [pgs_pkg::COORD_W-1:0]  point_y;
   modport source (output valid, point_x, point_y, input ready);
   modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface pgs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [pgs_pkg::COORD_W-1:0]  snap_x;
   logic signed [pgs_pkg::COORD_W-1:0]  snap_y;
   modport source (output valid, snap_x, snap_y, input ready);
   modport sink   (input valid, snap_x, snap_y, output ready);
endinterface

interface pgs_csr_if;
   logic                                valid;
   logic                                ready;
   logic [pgs_pkg::CSR_IDX_W-1:0]       index;
   logic [pgs_pkg::CSR_DATA_W-1:0]      data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/polar_grid_snap_top.sv
// Throughput: one point per cycle while the skid register is empty; up to 98 points
// can be in flight. Every stage takes a new point each cycle that the pipeline moves.
// The datapath is a chain of cells (20 vectoring, 48 divider, 20 rotation) and nine
// registers around it. Reset is synchronous and active high; it empties the pipeline
// and loads the default grid: origin 0, radius step 1.0, 8 divisions, no rotation.
module polar_grid_snap_top (
   input  logic      clock,
   input  logic      reset,
   pgs_csr_if.sink   csr_port,
   pgs_req_if.sink   req_port,
   pgs_rsp_if.source rsp_port
);
   import pgs_pkg::*;

   localparam logic signed [DATA_W-1:0] ROUND_HALF = DATA_W'(1) << (GUARD_W - 1);
   localparam logic signed [DATA_W-1:0] COORD_MAX  = DATA_W'({1'b0, {(COORD_W-1){1'b1}}});
   localparam logic signed [DATA_W-1:0] COORD_MIN  = -COORD_MAX - DATA_W'(1);

   // Clamp a wide signed value into the coordinate range.
   function automatic logic [COORD_W-1:0] sat_coord(input logic signed [DATA_W-1:0] v);
      logic [COORD_W-1:0] r;
      if (v > COORD_MAX) begin
         r = COORD_MAX[COORD_W-1:0];
      end else if (v < COORD_MIN) begin
         r = COORD_MIN[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers. Writes are always taken; the user must change the
   // grid only while no point is in flight (the block does not enforce this), so
   // every stage reads the registers directly instead of carrying a copy.
   // ---------------------------------------------------------------------
   logic [COORD_W-1:0] origin_x_ff;
   logic [COORD_W-1:0] origin_y_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [NDIV_W-1:0]  ndiv_ff;
   logic [ANGLE_W-1:0] rot_ff;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         step_ff     <= STEP_W'(65536);
         ndiv_ff     <= NDIV_W'(8);
         rot_ff      <= '0;
      end else if (csr_port.valid) begin
         unique case (csr_port.index)
            CSR_ORIGIN_X:       origin_x_ff <= csr_port.data;
            CSR_ORIGIN_Y:       origin_y_ff <= csr_port.data;
            CSR_RADIUS_STEP:    step_ff     <= csr_port.data[STEP_W-1:0];
            CSR_DIVISION_COUNT: ndiv_ff     <= csr_port.data[NDIV_W-1:0];
            CSR_ROTATION_ANGLE: rot_ff      <= csr_port.data[ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   // A zero step or zero division count acts as one.
   logic [STEP_W-1:0]  step_eff;
   logic [NDIV_W-1:0]  ndiv_eff;
   logic [PHASE_W-1:0] rot_phase;

   assign step_eff  = (step_ff == '0) ? STEP_W'(1) : step_ff;
   assign ndiv_eff  = (ndiv_ff == '0) ? NDIV_W'(1) : ndiv_ff;
   assign rot_phase = {rot_ff, {(PHASE_W-ANGLE_W){1'b0}}};

   // ---------------------------------------------------------------------
   // Flow control. The whole pipeline moves together while the skid
   // register is empty; the output register and the skid register let a
   // result wait on rsp while new points keep coming in.
   // ---------------------------------------------------------------------
   logic advance;
   logic skid_v_ff;

   assign advance        = ~skid_v_ff;
   assign req_port.ready = advance;

   // ---------------------------------------------------------------------
   // Entry stage: offset from the origin, guard bits, and the fold of the
   // left half plane onto the right one by a half turn.
   // ---------------------------------------------------------------------
   logic signed [COORD_W:0]   dx;
   logic signed [COORD_W:0]   dy;
   logic signed [DATA_W-1:0]  xg;
   logic signed [DATA_W-1:0]  yg;
   ctx_type                   a_ctx_in;
   ctx_type                   a_ctx_ff;
   vec_type                   a_vec_in;
   vec_type                   a_vec_ff;

   always_comb begin
      dx = {req_port.point_x[COORD_W-1], req_port.point_x}
         - {origin_x_ff[COORD_W-1], origin_x_ff};
      dy = {req_port.point_y[COORD_W-1], req_port.point_y}
         - {origin_y_ff[COORD_W-1], origin_y_ff};
      xg = DATA_W'(dx) <<< GUARD_W;
      yg = DATA_W'(dy) <<< GUARD_W;
      a_ctx_in           = '0;
      a_ctx_in.valid     = req_port.valid;
      a_ctx_in.on_origin = (dx == '0) && (dy == '0);
      if (dx[COORD_W]) begin
         a_vec_in.x   = -xg;
         a_vec_in.y   = -yg;
         a_vec_in.ang = HALF_TURN;
      end else begin
         a_vec_in.x   = xg;
         a_vec_in.y   = yg;
         a_vec_in.ang = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctx_ff <= '0;
      end else if (advance) begin
         a_ctx_ff <= a_ctx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_vec_ff <= a_vec_in;
      end
   end

   // ---------------------------------------------------------------------
   // Vectoring chain: distance in x (with CORDIC gain), angle in ang.
   // ---------------------------------------------------------------------
   ctx_type vc_ctx [0:CORDIC_STAGES];
   vec_type vc_vec [0:CORDIC_STAGES];

   assign vc_ctx[0] = a_ctx_ff;
   assign vc_vec[0] = a_vec_ff;

   genvar gi;
   for (gi = 0; gi < CORDIC_STAGES; gi++) begin : g_vec
      pgs_cordic_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .mode    (MODE_VECTOR),
         .stage   (STAGE_IDX_W'(gi)),
         .ctx_i   (vc_ctx[gi]),
         .vec_i   (vc_vec[gi]),
         .ctx_o   (vc_ctx[gi+1]),
         .vec_o   (vc_vec[gi+1])
      );
   end

   // ---------------------------------------------------------------------
   // Gain removal on the distance runs alongside the angle arithmetic:
   // the signed offset from the grid rotation, then its product with N.
   // ---------------------------------------------------------------------
   logic [DATA_W-1:0]   dist_clamped;
   logic [DATA_W-1:0]   dist_scaled;
   logic signed [33:0]  t_diff;
   ctx_type             b_ctx_in;
   ctx_type             b_ctx_ff;
   logic [32:0]         b_at_in;
   logic [32:0]         b_at_ff;
   ctx_type             c_ctx_ff;
   logic [45:0]         c_prod_in;
   logic [45:0]         c_prod_ff;

   always_comb begin
      dist_clamped = vc_vec[CORDIC_STAGES].x[DATA_W-1] ? '0
                   : vc_vec[CORDIC_STAGES].x;
      t_diff       = {2'b00, vc_vec[CORDIC_STAGES].ang} - {2'b00, rot_phase};
      b_ctx_in     = vc_ctx[CORDIC_STAGES];
      b_ctx_in.neg = t_diff[33];
      b_at_in      = t_diff[33] ? 33'(-t_diff) : t_diff[32:0];
      c_prod_in    = b_at_ff * ndiv_eff;
   end

   pgs_gain_unit u_gain_dist (
      .clock     (clock),
      .advance   (advance),
      .value_i   (dist_clamped),
      .product_o (dist_scaled)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctx_ff <= '0;
         c_ctx_ff <= '0;
      end else if (advance) begin
         b_ctx_ff <= b_ctx_in;
         c_ctx_ff <= b_ctx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_at_ff   <= b_at_in;
         c_prod_ff <= c_prod_in;
      end
   end

   // ---------------------------------------------------------------------
   // Dividends for the two divisions. Radius: round half up to a whole
   // number of steps; the guard bits drop out of numerator and divisor.
   // Angle: k = nearest index with ties away from zero, then the target
   // offset k * 2^32 / 2N, rounded.
   // ---------------------------------------------------------------------
   logic [DATA_W-1:0] rad_sum;
   logic [46:0]       k_sum;
   ctx_type           d_ctx_in;
   ctx_type           d_ctx_ff;
   div_lane_type      d_lane_r_in;
   div_lane_type      d_lane_r_ff;
   div_lane_type      d_lane_a_in;
   div_lane_type      d_lane_a_ff;

   always_comb begin
      rad_sum          = dist_scaled + (DATA_W'(step_eff) << (GUARD_W - 1));
      k_sum            = {1'b0, c_prod_ff} + 47'h4000_0000;
      d_lane_r_in.rem  = '0;
      d_lane_r_in.nq   = DIV_W'(rad_sum >> GUARD_W);
      d_lane_a_in.rem  = '0;
      d_lane_a_in.nq   = {k_sum[46:31], 32'b0} + DIV_W'(ndiv_eff);
      d_ctx_in         = c_ctx_ff;
      d_ctx_in.side    = DATA_W'(d_lane_r_in.nq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ctx_ff <= '0;
      end else if (advance) begin
         d_ctx_ff <= d_ctx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_lane_r_ff <= d_lane_r_in;
         d_lane_a_ff <= d_lane_a_in;
      end
   end

   // ---------------------------------------------------------------------
   // Divider chain: one quotient bit per cell in both lanes.
   // ---------------------------------------------------------------------
   logic [DEN_W-1:0] den_r;
   logic [DEN_W-1:0] den_a;
   ctx_type          dv_ctx  [0:DIV_W];
   div_lane_type     dv_lr   [0:DIV_W];
   div_lane_type     dv_la   [0:DIV_W];

   assign den_r     = DEN_W'(step_eff);
   assign den_a     = DEN_W'({ndiv_eff, 1'b0});
   assign dv_ctx[0] = d_ctx_ff;
   assign dv_lr[0]  = d_lane_r_ff;
   assign dv_la[0]  = d_lane_a_ff;

   for (gi = 0; gi < DIV_W; gi++) begin : g_div
      pgs_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .den_r    (den_r),
         .den_a    (den_a),
         .ctx_i    (dv_ctx[gi]),
         .lane_r_i (dv_lr[gi]),
         .lane_a_i (dv_la[gi]),
         .ctx_o    (dv_ctx[gi+1]),
         .lane_r_o (dv_lr[gi+1]),
         .lane_a_o (dv_la[gi+1])
      );
   end

   // ---------------------------------------------------------------------
   // Snapped radius is the dividend less the remainder, i.e. quotient
   // times step. The snapped phase is split into the nearest quarter turn
   // and a small residual for the rotation chain.
   // ---------------------------------------------------------------------
   logic [PHASE_W-1:0] off;
   logic [PHASE_W-1:0] phase;
   logic [PHASE_W-1:0] quad_sum;
   logic [PHASE_W-1:0] resid;
   logic [DATA_W-1:0]  rad_q;
   ctx_type            e_ctx_in;
   ctx_type            e_ctx_ff;
   logic [PHASE_W-1:0] e_ang_ff;
   ctx_type            f_ctx_ff;
   logic [PHASE_W-1:0] f_ang_ff;
   ctx_type            g_ctx_ff;
   logic [PHASE_W-1:0] g_ang_ff;
   logic [DATA_W-1:0]  rad_scaled;

   always_comb begin
      rad_q    = dv_ctx[DIV_W].side - DATA_W'(dv_lr[DIV_W].rem);
      off      = dv_la[DIV_W].nq[PHASE_W-1:0];
      phase    = dv_ctx[DIV_W].neg ? (rot_phase - off) : (rot_phase + off);
      quad_sum = phase + 32'h2000_0000;
      resid    = phase - {quad_sum[31:30], 30'b0};
      e_ctx_in      = dv_ctx[DIV_W];
      e_ctx_in.quad = quad_sum[31:30];
      e_ctx_in.axis = (resid == '0);
      e_ctx_in.side = rad_q << GUARD_W;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ctx_ff <= '0;
         f_ctx_ff <= '0;
         g_ctx_ff <= '0;
      end else if (advance) begin
         e_ctx_ff <= e_ctx_in;
         f_ctx_ff <= e_ctx_ff;
         g_ctx_ff <= f_ctx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e_ang_ff <= resid;
         f_ang_ff <= e_ang_ff;
         g_ang_ff <= f_ang_ff;
      end
   end

   // Gain is taken out of the radius before it is rotated.
   pgs_gain_unit u_gain_rad (
      .clock     (clock),
      .advance   (advance),
      .value_i   (e_ctx_ff.side),
      .product_o (rad_scaled)
   );

   // ---------------------------------------------------------------------
   // Rotation chain: turns the radius by the residual angle.
   // ---------------------------------------------------------------------
   ctx_type rc_ctx [0:CORDIC_STAGES];
   vec_type rc_vec [0:CORDIC_STAGES];

   always_comb begin
      rc_ctx[0]     = g_ctx_ff;
      rc_vec[0].x   = rad_scaled;
      rc_vec[0].y   = '0;
      rc_vec[0].ang = g_ang_ff;
   end

   for (gi = 0; gi < CORDIC_STAGES; gi++) begin : g_rot
      pgs_cordic_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .mode    (MODE_ROTATE),
         .stage   (STAGE_IDX_W'(gi)),
         .ctx_i   (rc_ctx[gi]),
         .vec_i   (rc_vec[gi]),
         .ctx_o   (rc_ctx[gi+1]),
         .vec_o   (rc_vec[gi+1])
      );
   end

   // ---------------------------------------------------------------------
   // Quarter-turn placement. An exact axis direction skips the rotation
   // and uses the radius as it is.
   // ---------------------------------------------------------------------
   logic signed [DATA_W-1:0] cx;
   logic signed [DATA_W-1:0] cy;
   logic signed [DATA_W-1:0] h_fx_in;
   logic signed [DATA_W-1:0] h_fy_in;
   logic signed [DATA_W-1:0] h_fx_ff;
   logic signed [DATA_W-1:0] h_fy_ff;
   ctx_type                  h_ctx_ff;

   always_comb begin
      if (rc_ctx[CORDIC_STAGES].axis) begin
         cx = rc_ctx[CORDIC_STAGES].side;
         cy = '0;
      end else begin
         cx = rc_vec[CORDIC_STAGES].x;
         cy = rc_vec[CORDIC_STAGES].y;
      end
      case (rc_ctx[CORDIC_STAGES].quad)
         2'd1: begin
            h_fx_in = -cy;
            h_fy_in = cx;
         end
         2'd2: begin
            h_fx_in = -cx;
            h_fy_in = -cy;
         end
         2'd3: begin
            h_fx_in = cy;
            h_fy_in = -cx;
         end
         default: begin
            h_fx_in = cx;
            h_fy_in = cy;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ctx_ff <= '0;
      end else if (advance) begin
         h_ctx_ff <= rc_ctx[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         h_fx_ff <= h_fx_in;
         h_fy_ff <= h_fy_in;
      end
   end

   // ---------------------------------------------------------------------
   // Guard bits off (half up), back onto the origin, saturate. A point on
   // the origin returns the origin.
   // ---------------------------------------------------------------------
   logic signed [DATA_W-1:0] ox_w;
   logic signed [DATA_W-1:0] oy_w;
   logic signed [DATA_W-1:0] node_x;
   logic signed [DATA_W-1:0] node_y;
   logic [COORD_W-1:0]       res_x;
   logic [COORD_W-1:0]       res_y;

   always_comb begin
      ox_w   = DATA_W'($signed(origin_x_ff));
      oy_w   = DATA_W'($signed(origin_y_ff));
      node_x = ((h_fx_ff + ROUND_HALF) >>> GUARD_W) + ox_w;
      node_y = ((h_fy_ff + ROUND_HALF) >>> GUARD_W) + oy_w;
      if (h_ctx_ff.on_origin) begin
         res_x = origin_x_ff;
         res_y = origin_y_ff;
      end else begin
         res_x = sat_coord(node_x);
         res_y = sat_coord(node_y);
      end
   end

   // ---------------------------------------------------------------------
   // Output register with a skid register behind it. A result that finds
   // the output register busy and not being taken parks in the skid
   // register, which then holds the pipeline for as long as it is full.
   // ---------------------------------------------------------------------
   logic               out_v_ff;
   logic [COORD_W-1:0] out_x_ff;
   logic [COORD_W-1:0] out_y_ff;
   logic [COORD_W-1:0] skid_x_ff;
   logic [COORD_W-1:0] skid_y_ff;
   logic               out_free;

   assign out_free = ~out_v_ff | rsp_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (out_free) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end
      end else if (h_ctx_ff.valid) begin
         if (out_free) begin
            out_v_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (rsp_port.ready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (out_free) begin
            out_x_ff <= skid_x_ff;
            out_y_ff <= skid_y_ff;
         end
      end else if (h_ctx_ff.valid) begin
         if (out_free) begin
            out_x_ff <= res_x;
            out_y_ff <= res_y;
         end else begin
            skid_x_ff <= res_x;
            skid_y_ff <= res_y;
         end
      end
   end

   assign rsp_port.valid  = out_v_ff;
   assign rsp_port.snap_x = out_x_ff;
   assign rsp_port.snap_y = out_y_ff;

endmodule

### hw/rtl/pgs_cordic_cell.sv
module pgs_cordic_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             mode,
   input  logic [pgs_pkg::STAGE_IDX_W-1:0]  stage,
   input  pgs_pkg::ctx_type                 ctx_i,
   input  pgs_pkg::vec_type                 vec_i,
   output pgs_pkg::ctx_type                 ctx_o,
   output pgs_pkg::vec_type                 vec_o
);
   import pgs_pkg::*;

   logic signed [DATA_W-1:0] x_s;
   logic signed [DATA_W-1:0] y_s;
   logic signed [DATA_W-1:0] xs;
   logic signed [DATA_W-1:0] ys;
   logic [PHASE_W-1:0]       delta;
   logic                     ccw;
   vec_type                  vec_in;
   vec_type                  vec_ff;
   ctx_type                  ctx_ff;

   // One micro-rotation. Vectoring drives y toward zero, rotation drives
   // the residual angle toward zero; both turn the same way for ccw.
   always_comb begin
      x_s   = vec_i.x;
      y_s   = vec_i.y;
      xs    = x_s >>> stage;
      ys    = y_s >>> stage;
      delta = atan_phase(stage);
      ccw   = (mode == MODE_ROTATE) ? ~vec_i.ang[PHASE_W-1] : y_s[DATA_W-1];
      if (ccw) begin
         vec_in.x   = x_s - ys;
         vec_in.y   = y_s + xs;
         vec_in.ang = vec_i.ang - delta;
      end else begin
         vec_in.x   = x_s + ys;
         vec_in.y   = y_s - xs;
         vec_in.ang = vec_i.ang + delta;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff <= '0;
      end else if (advance) begin
         ctx_ff <= ctx_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vec_ff <= vec_in;
      end
   end

   assign ctx_o = ctx_ff;
   assign vec_o = vec_ff;

endmodule

### hw/rtl/pgs_div_cell.sv
module pgs_div_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [pgs_pkg::DEN_W-1:0]   den_r,
   input  logic [pgs_pkg::DEN_W-1:0]   den_a,
   input  pgs_pkg::ctx_type            ctx_i,
   input  pgs_pkg::div_lane_type       lane_r_i,
   input  pgs_pkg::div_lane_type       lane_a_i,
   output pgs_pkg::ctx_type            ctx_o,
   output pgs_pkg::div_lane_type       lane_r_o,
   output pgs_pkg::div_lane_type       lane_a_o
);
   import pgs_pkg::*;

   ctx_type      ctx_ff;
   div_lane_type lane_r_in;
   div_lane_type lane_r_ff;
   div_lane_type lane_a_in;
   div_lane_type lane_a_ff;

   // One restoring step: bring in the next dividend bit, subtract if it
   // fits, and shift the quotient bit in where the dividend bit left.
   function automatic div_lane_type div_step(input div_lane_type l,
                                             input logic [DEN_W-1:0] den);
      logic [REM_W-1:0] part;
      logic             q_bit;
      div_lane_type     res;
      part  = {l.rem[REM_W-2:0], l.nq[DIV_W-1]};
      q_bit = (part >= {1'b0, den});
      res.rem = q_bit ? (part - {1'b0, den}) : part;
      res.nq  = {l.nq[DIV_W-2:0], q_bit};
      return res;
   endfunction

   always_comb begin
      lane_r_in = div_step(lane_r_i, den_r);
      lane_a_in = div_step(lane_a_i, den_a);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff <= '0;
      end else if (advance) begin
         ctx_ff <= ctx_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_r_ff <= lane_r_in;
         lane_a_ff <= lane_a_in;
      end
   end

   assign ctx_o    = ctx_ff;
   assign lane_r_o = lane_r_ff;
   assign lane_a_o = lane_a_ff;

endmodule

### hw/rtl/pgs_gain_unit.sv
module pgs_gain_unit (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [pgs_pkg::DATA_W-1:0]  value_i,
   output logic [pgs_pkg::DATA_W-1:0]  product_o
);
   import pgs_pkg::*;

   logic [47:0]       hi_in;
   logic [47:0]       hi_ff;
   logic [39:0]       mid_in;
   logic [39:0]       mid_ff;
   logic [47:0]       lo_in;
   logic [47:0]       lo_ff;
   logic [47:0]       lo_round;
   logic [DATA_W-1:0] prod_in;
   logic [DATA_W-1:0] prod_ff;

   // The value is cut into three slices so that each product stays narrow;
   // only the lowest slice is rounded, half up.
   always_comb begin
      hi_in    = value_i[63:40] * KINV;
      mid_in   = value_i[39:24] * KINV;
      lo_in    = value_i[23:0] * KINV;
      lo_round = lo_ff + 48'h80_0000;
      prod_in  = {hi_ff, 16'b0} + DATA_W'(mid_ff) + DATA_W'(lo_round[47:24]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hi_ff   <= hi_in;
         mid_ff  <= mid_in;
         lo_ff   <= lo_in;
         prod_ff <= prod_in;
      end
   end

   assign product_o = prod_ff;

endmodule
